>>> design/lms_pkg.sv
package lms_pkg;

  // Default output budget line length
  localparam int LINE_MAX_DEF = 1024;

  // Entries in the queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Parse phases
  localparam logic [1:0] PH_FIRST = 2'd0;
  localparam logic [1:0] PH_PRIO  = 2'd1;
  localparam logic [1:0] PH_BODY  = 2'd2;

  // Characters
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_DEL    = 8'h7F;
  localparam logic [7:0] CTRL_BIT  = 8'h40;

  localparam logic [15:0] PRIO_MAX = 16'hFFFF;

  // Expansion of one input word: last is the index of the final byte
  typedef struct packed {
    logic [1:0]      last;
    logic [3:0][7:0] bytes;
  } lms_cmd_t;

  // Queue status seen by the front and back
  typedef struct packed {
    logic full;
    logic empty;
  } lms_qstat_t;

  // Rewrite one body byte into its printable form
  function automatic lms_cmd_t lms_expand(input logic [7:0] b);
    lms_cmd_t c;
    c.last  = 2'd0;
    c.bytes = '0;
    if (b == CH_NL) begin
      c.bytes[0] = CH_SPACE;
    end else if (b < CH_SPACE) begin
      c.last     = 2'd1;
      c.bytes[0] = CH_CARET;
      c.bytes[1] = b | CTRL_BIT;
    end else if (b == CH_DEL || (b & CH_DEL) < CH_SPACE) begin
      c.last     = 2'd3;
      c.bytes[0] = CH_BSLASH;
      c.bytes[1] = CH_ZERO | {6'd0, b[7:6]};
      c.bytes[2] = CH_ZERO | {5'd0, b[5:3]};
      c.bytes[3] = CH_ZERO | {5'd0, b[2:0]};
    end else begin
      c.bytes[0] = b;
    end
    return c;
  endfunction

endpackage

>>> design/lms_front.sv
module lms_front import lms_pkg::*; #(
  parameter int LINE_MAX = LINE_MAX_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] in_byte
  input  lms_qstat_t qstat,
  output logic       push,
  output lms_cmd_t   cmd
);

  localparam int CW = $clog2(2 * LINE_MAX);
  localparam logic [CW-1:0] BUDGET = CW'(2 * LINE_MAX - 4);

  logic [1:0]    phase, phase_next;
  logic [15:0]   prio, prio_next;
  logic [CW-1:0] count, count_next;

  logic          acc;
  logic          body;
  lms_cmd_t      body_cmd;
  logic [19:0]   prio_mul;
  logic [3:0]    digit;

  assign s_tready = !qstat.full;
  assign acc      = s_tvalid && s_tready;
  assign body_cmd = lms_expand(s_tdata);
  assign digit    = s_tdata[3:0];
  assign prio_mul = {1'b0, prio, 3'd0} + {3'd0, prio, 1'b0} + {16'd0, digit};

  // Classify the word and update the parse state
  always_comb begin
    phase_next = phase;
    prio_next  = prio;
    count_next = count;
    body       = 1'b0;
    push       = 1'b0;
    cmd        = body_cmd;
    if (acc) begin
      if (s_tdata == CH_NUL) begin
        push       = 1'b1;
        cmd.last   = 2'd2;
        cmd.bytes  = {CH_NUL, CH_NUL, prio[7:0], prio[15:8]};
        phase_next = PH_FIRST;
        prio_next  = '0;
        count_next = '0;
      end else begin
        case (phase)
          PH_FIRST: begin
            if (s_tdata == CH_LT) begin
              phase_next = PH_PRIO;
            end else begin
              phase_next = PH_BODY;
              body       = 1'b1;
            end
          end
          PH_PRIO: begin
            if (s_tdata >= CH_ZERO && s_tdata <= CH_NINE) begin
              prio_next = (prio_mul[19:16] != 4'd0) ? PRIO_MAX : prio_mul[15:0];
            end else begin
              phase_next = PH_BODY;
              body       = (s_tdata != CH_GT);
            end
          end
          default: begin
            body = 1'b1;
          end
        endcase
        // Drop body bytes once the budget is spent
        if (body && count < BUDGET) begin
          push       = 1'b1;
          count_next = count + CW'(body_cmd.last) + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_FIRST;
      prio  <= '0;
      count <= '0;
    end else begin
      phase <= phase_next;
      prio  <= prio_next;
      count <= count_next;
    end
  end

endmodule

>>> design/lms_queue.sv
module lms_queue import lms_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  lms_cmd_t   wr_cmd,
  input  logic       pop,
  output lms_cmd_t   rd_cmd,
  output lms_qstat_t qstat
);

  lms_cmd_t            mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr, rd_ptr;
  logic [QPTR_W:0]     fill;

  assign rd_cmd      = mem[rd_ptr];
  assign qstat.full  = (fill == (QPTR_W+1)'(QUEUE_DEPTH));
  assign qstat.empty = (fill == '0);

  // Store pushed entries
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_cmd;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + (QPTR_W+1)'(1);
      end else if (pop && !push) begin
        fill <= fill - (QPTR_W+1)'(1);
      end
    end
  end

endmodule

>>> design/lms_back.sv
module lms_back import lms_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  lms_qstat_t qstat,
  input  lms_cmd_t   rd_cmd,
  output logic       pop,
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata    // [7:0] out_byte
);

  lms_cmd_t   cur;
  logic       cur_valid;
  logic [1:0] idx;
  logic       done;

  assign m_tvalid = cur_valid;
  assign m_tdata  = cur.bytes[idx];
  assign done     = m_tvalid && m_tready && (idx == cur.last);
  assign pop      = !qstat.empty && (!cur_valid || done);

  // Hold the current entry, step through its bytes
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= '0;
    end else if (pop) begin
      cur_valid <= 1'b1;
      idx       <= '0;
    end else if (done) begin
      cur_valid <= 1'b0;
      idx       <= '0;
    end else if (m_tvalid && m_tready) begin
      idx <= idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= rd_cmd;
    end
  end

endmodule

>>> design/log_message_scrubber.sv
// Throughput: one input word per cycle while the queue has room; one output word
// per cycle while m_tready is high; a word expands to zero to four output words,
// set by the byte expansion and stepped out by the back stage.
// Reset: synchronous rst clears parse state, priority, count, queue and output.
module log_message_scrubber import lms_pkg::*; #(
  parameter int LINE_MAX = LINE_MAX_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] in_byte
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata    // [7:0] out_byte
);

  lms_qstat_t qstat;
  lms_cmd_t   wr_cmd, rd_cmd;
  logic       push, pop;

  lms_front #(.LINE_MAX(LINE_MAX)) u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .qstat    (qstat),
    .push     (push),
    .cmd      (wr_cmd)
  );

  lms_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_cmd (wr_cmd),
    .pop    (pop),
    .rd_cmd (rd_cmd),
    .qstat  (qstat)
  );

  lms_back u_back (
    .clk      (clk),
    .rst      (rst),
    .qstat    (qstat),
    .rd_cmd   (rd_cmd),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

>>> design/lms_checker.sv
module lms_props (
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata
);

  logic s_acc;
  assign s_acc = s_tvalid && s_tready;

  // Output is empty right after reset
  a_reset_out: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  // Queue is empty right after reset, so input is ready
  a_reset_in: assert property (@(posedge clk) rst |=> s_tready)
    else $error("input not ready after reset");

  // Without input words the idle output stays idle
  a_no_invent: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid && !s_acc && !$past(s_acc) |=> !m_tvalid)
    else $error("output word without input");

  // Stalled output word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled output word changed");

endmodule

bind log_message_scrubber lms_props u_lms_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

>>> bench/lms_checker.sv
module lms_checker import lms_pkg::*; #(
  parameter int LINE_MAX = LINE_MAX_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  input  logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] in_byte
  input  logic       m_tvalid,
  input  logic       m_tready,
  input  logic [7:0] m_tdata,   // [7:0] out_byte
  output int         err_count,
  output int         pending
);

  logic [7:0] expected_chars[$];
  logic [1:0] scrub_phase;
  logic [15:0] scrub_prio;
  int         body_count;

  // Queue the printable form of one body byte while the budget allows
  task automatic push_body(input logic [7:0] b);
    if (body_count < 2 * LINE_MAX - 4) begin
      if (b == CH_NL) begin
        expected_chars.push_back(CH_SPACE);
        body_count += 1;
      end else if (b < CH_SPACE) begin
        expected_chars.push_back(CH_CARET);
        expected_chars.push_back(b | CTRL_BIT);
        body_count += 2;
      end else if (b == CH_DEL || (b >= 8'h80 && b < 8'hA0)) begin
        // Backslash and three octal digits, most significant first
        expected_chars.push_back(CH_BSLASH);
        expected_chars.push_back(CH_ZERO + {6'd0, b[7:6]});
        expected_chars.push_back(CH_ZERO + {5'd0, b[5:3]});
        expected_chars.push_back(CH_ZERO + {5'd0, b[2:0]});
        body_count += 4;
      end else begin
        expected_chars.push_back(b);
        body_count += 1;
      end
    end
  endtask

  // Advance the scrubber state by one input word and queue what it emits
  task automatic predict_scrub(input logic [7:0] b);
    int p;
    if (b == CH_NUL) begin
      // Terminator: priority high, low, then the end mark
      expected_chars.push_back(scrub_prio[15:8]);
      expected_chars.push_back(scrub_prio[7:0]);
      expected_chars.push_back(CH_NUL);
      scrub_phase = PH_FIRST;
      scrub_prio  = '0;
      body_count  = 0;
    end else if (scrub_phase == PH_FIRST) begin
      if (b == CH_LT) begin
        scrub_phase = PH_PRIO;
      end else begin
        scrub_phase = PH_BODY;
        push_body(b);
      end
    end else if (scrub_phase == PH_PRIO) begin
      if (b >= CH_ZERO && b <= CH_NINE) begin
        // Accumulate decimal digits, saturating
        p = int'(scrub_prio) * 10 + int'(b - CH_ZERO);
        scrub_prio = (p > int'(PRIO_MAX)) ? PRIO_MAX : p[15:0];
      end else begin
        scrub_phase = PH_BODY;
        if (b != CH_GT) push_body(b);
      end
    end else begin
      push_body(b);
    end
  endtask

  // Compare output words first, then predict from the accepted input word
  always @(posedge clk) begin
    logic [7:0] want;
    if (rst) begin
      expected_chars.delete();
      scrub_phase = PH_FIRST;
      scrub_prio  = '0;
      body_count  = 0;
      err_count   = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_chars.size() == 0) begin
          err_count++;
          if (err_count <= 10)
            $display("%0t: unexpected output word %02h", $realtime, m_tdata);
        end else begin
          want = expected_chars.pop_front();
          if (m_tdata !== want) begin
            err_count++;
            if (err_count <= 10)
              $display("%0t: out_byte expected %02h got %02h", $realtime, want, m_tdata);
          end
        end
      end
      if (s_tvalid && s_tready) predict_scrub(s_tdata);
    end
    pending <= expected_chars.size();
  end

endmodule

>>> bench/tb_log_message_scrubber.sv
module tb_log_message_scrubber;
  import lms_pkg::*;

  // Small line length so the output budget is reached by short messages
  localparam int LINE_MAX  = 64;
  localparam int MIN_ITEMS = 250;

  logic       clk      = 1'b0;
  logic       rst      = 1'b1;
  logic       s_tvalid = 1'b0;
  logic [7:0] s_tdata  = 8'h00;
  logic       m_tready = 1'b0;
  logic       s_tready;
  logic       m_tvalid;
  logic [7:0] m_tdata;
  int         mismatches;
  int         waiting;
  logic [7:0] msg_bytes[$];

  always #2 clk = ~clk;

  log_message_scrubber #(.LINE_MAX(LINE_MAX)) u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  lms_checker #(.LINE_MAX(LINE_MAX)) u_checker (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .err_count (mismatches),
    .pending   (waiting)
  );

  // Pick a body byte, weighted toward the rewrite classes
  function automatic logic [7:0] rand_body_byte();
    case ($urandom_range(0, 5))
      0: return 8'($urandom_range(1, 31));
      1: return CH_NL;
      2: return ($urandom_range(0, 3) == 0) ? CH_DEL : 8'($urandom_range(8'h80, 8'h9F));
      3: return 8'($urandom_range(8'h20, 8'h7E));
      4: return 8'($urandom_range(8'hA0, 8'hFF));
      default: return 8'($urandom_range(1, 255));
    endcase
  endfunction

  // Append one message: mostly well formed, some plain, broken or overlong
  task automatic add_message();
    int kind;
    int len;
    kind = $urandom_range(0, 9);
    if (kind != 6 && kind != 7) begin
      msg_bytes.push_back(CH_LT);
      repeat ((kind == 8) ? $urandom_range(0, 3) : $urandom_range(1, 6))
        msg_bytes.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
      if (kind != 8) msg_bytes.push_back(CH_GT);
    end
    case (kind)
      8:       len = $urandom_range(0, 10);
      9:       len = $urandom_range(35, 60);
      default: len = $urandom_range(0, 30);
    endcase
    repeat (len) msg_bytes.push_back(rand_body_byte());
    msg_bytes.push_back(CH_NUL);
  endtask

  // Run limit
  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Output side: random stalls, calm stretches and two long hold-offs
  initial begin
    int  gap;
    int  taken;
    bit  calm;
    taken = 0;
    calm  = 1'b0;
    @(negedge rst);
    forever begin
      if ($urandom_range(0, 15) == 0) calm = !calm;
      gap = calm ? 0 : $urandom_range(0, 16);
      if (taken == 150 || taken == 450) gap = 400;
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      taken++;
    end
  end

  // Input side and verdict
  initial begin
    int gap;
    bit calm;
    calm = 1'b0;
    // Priority with '>', newline; overflowing priority ended by a control byte,
    // then control, octal and plain bytes; lone '<'; empty message; escape as first byte
    msg_bytes = {CH_LT, 8'h37, CH_GT, 8'h41, CH_NL, CH_NUL,
                 CH_LT, CH_NINE, CH_NINE, CH_NINE, CH_NINE, CH_NINE,
                 8'h01, CH_DEL, 8'h80, 8'h9F, 8'hA0, 8'hFF, 8'h1F, CH_NUL,
                 CH_LT, CH_NUL,
                 CH_NUL,
                 8'h9F, CH_NUL};
    while (msg_bytes.size() < MIN_ITEMS) add_message();

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (msg_bytes[i]) begin
      if ($urandom_range(0, 15) == 0) calm = !calm;
      gap = calm ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      s_tvalid <= 1'b1;
      s_tdata  <= msg_bytes[i];
      @(posedge clk);
      while (!s_tready) @(posedge clk);
    end
    s_tvalid <= 1'b0;

    // Drain, then let any stray word show up
    @(posedge clk);
    while (waiting != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
